// ----- hw/rtl/ycbcr_to_rgba_pixel_unit_defines.svh -----
// Assertion macros for the YCbCr to RGBA pixel unit.
`ifndef YCBCR_TO_RGBA_PIXEL_UNIT_DEFINES_SVH
`define YCBCR_TO_RGBA_PIXEL_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define YCRGB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define YCRGB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/ycrgb_pkg.sv -----
// Shared types and constants for the YCbCr to RGBA pixel unit.
`default_nettype none

package ycrgb_pkg;

    // Product and sum widths of the color matrix (signed).
    localparam int PW = 27;
    localparam int SW = 28;

    // BT.601 coefficients, 16 fractional bits.
    localparam logic [17:0] K_Y_FULL   = 18'd65536;
    localparam logic [17:0] K_Y_LIM    = 18'd76309;
    localparam logic [17:0] K_RCR_FULL = 18'd91881;
    localparam logic [17:0] K_RCR_LIM  = 18'd104597;
    localparam logic [17:0] K_GCB_FULL = 18'd22554;
    localparam logic [17:0] K_GCB_LIM  = 18'd25675;
    localparam logic [17:0] K_GCR_FULL = 18'd46802;
    localparam logic [17:0] K_GCR_LIM  = 18'd53279;
    localparam logic [17:0] K_BCB_FULL = 18'd116130;
    localparam logic [17:0] K_BCB_LIM  = 18'd132201;

    // Rounding offsets; full-range green rounds the subtracted term the other way.
    localparam logic signed [SW-1:0] RND_HALF    = 28'sd32768;
    localparam logic signed [SW-1:0] RND_HALF_DN = 28'sd32767;

    localparam logic [7:0] LUMA_BLACK = 8'd16;
    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
    localparam logic [15:0] PREMUL_RND = 16'd127;

    // floor(x / 255) == (x * 32897) >> 23 for x < 2^16
    localparam logic [15:0] RECIP_255 = 16'd32897;
    localparam int RECIP_SHIFT = 23;

    typedef enum logic [1:0] {
        CFG_FULL_RANGE    = 2'd0,
        CFG_ALPHA_PRESENT = 2'd1,
        CFG_PREMULTIPLY   = 2'd2
    } t_cfg_idx;

    // Load strobes for the two matrix stages.
    typedef struct packed {
        logic ld1;
        logic ld2;
    } t_mtx_ctl;

endpackage

`default_nettype wire

// ----- hw/rtl/ycrgb_matrix.sv -----
// Color matrix: coefficient products, then rounded sums and clamp to bytes.
`default_nettype none

module ycrgb_matrix (
    input  logic                i_clk,
    input  ycrgb_pkg::t_mtx_ctl i_ctl,
    input  logic                i_full_range,
    input  logic                i_alpha_present,
    input  logic [7:0]          i_luma,
    input  logic [7:0]          i_blue_chroma,
    input  logic [7:0]          i_red_chroma,
    input  logic [7:0]          i_alpha_in,
    output logic [7:0]          o_red,
    output logic [7:0]          o_green,
    output logic [7:0]          o_blue,
    output logic [7:0]          o_alpha
);

    localparam int PW = ycrgb_pkg::PW;
    localparam int SW = ycrgb_pkg::SW;

    function automatic logic [7:0] clamp_u8(input logic signed [SW-1:0] s);
        logic neg;
        logic over;
        neg  = s[SW-1];
        over = |s[SW-2:24];
        if (neg) begin
            return 8'd0;
        end else if (over) begin
            return 8'd255;
        end
        return s[23:16];
    endfunction

    logic [7:0]               y_lim;
    logic [7:0]               y_fac;
    logic signed [7:0]        cb_s;
    logic signed [7:0]        cr_s;
    logic signed [PW-1:0]     y_x;
    logic signed [PW-1:0]     cb_x;
    logic signed [PW-1:0]     cr_x;
    logic signed [PW-1:0]     k_y;
    logic signed [PW-1:0]     k_rcr;
    logic signed [PW-1:0]     k_gcb;
    logic signed [PW-1:0]     k_gcr;
    logic signed [PW-1:0]     k_bcb;

    logic signed [PW-1:0]     n1_y;
    logic signed [PW-1:0]     n1_rcr;
    logic signed [PW-1:0]     n1_gcb;
    logic signed [PW-1:0]     n1_gcr;
    logic signed [PW-1:0]     n1_bcb;
    logic [7:0]               n1_alpha;
    logic signed [PW-1:0]     r1_y;
    logic signed [PW-1:0]     r1_rcr;
    logic signed [PW-1:0]     r1_gcb;
    logic signed [PW-1:0]     r1_gcr;
    logic signed [PW-1:0]     r1_bcb;
    logic [7:0]               r1_alpha;

    logic signed [SW-1:0]     sum_r;
    logic signed [SW-1:0]     sum_g;
    logic signed [SW-1:0]     sum_b;
    logic signed [SW-1:0]     rnd_g;
    logic [7:0]               r2_red;
    logic [7:0]               r2_green;
    logic [7:0]               r2_blue;
    logic [7:0]               r2_alpha;

    // Stage 1: one multiplier per term; full range scales luma by 1.0.
    always_comb begin
        y_lim = (i_luma > ycrgb_pkg::LUMA_BLACK) ? (i_luma - ycrgb_pkg::LUMA_BLACK) : 8'd0;
        y_fac = i_full_range ? i_luma : y_lim;
        cb_s  = $signed({~i_blue_chroma[7], i_blue_chroma[6:0]});
        cr_s  = $signed({~i_red_chroma[7], i_red_chroma[6:0]});
        y_x   = $signed(PW'(y_fac));
        cb_x  = PW'(cb_s);
        cr_x  = PW'(cr_s);
        k_y   = $signed(PW'(i_full_range ? ycrgb_pkg::K_Y_FULL   : ycrgb_pkg::K_Y_LIM));
        k_rcr = $signed(PW'(i_full_range ? ycrgb_pkg::K_RCR_FULL : ycrgb_pkg::K_RCR_LIM));
        k_gcb = $signed(PW'(i_full_range ? ycrgb_pkg::K_GCB_FULL : ycrgb_pkg::K_GCB_LIM));
        k_gcr = $signed(PW'(i_full_range ? ycrgb_pkg::K_GCR_FULL : ycrgb_pkg::K_GCR_LIM));
        k_bcb = $signed(PW'(i_full_range ? ycrgb_pkg::K_BCB_FULL : ycrgb_pkg::K_BCB_LIM));
        n1_y     = y_x * k_y;
        n1_rcr   = cr_x * k_rcr;
        n1_gcb   = cb_x * k_gcb;
        n1_gcr   = cr_x * k_gcr;
        n1_bcb   = cb_x * k_bcb;
        n1_alpha = i_alpha_present ? i_alpha_in : ycrgb_pkg::ALPHA_OPAQUE;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld1) begin
            r1_y     <= n1_y;
            r1_rcr   <= n1_rcr;
            r1_gcb   <= n1_gcb;
            r1_gcr   <= n1_gcr;
            r1_bcb   <= n1_bcb;
            r1_alpha <= n1_alpha;
        end
    end

    // Stage 2: add, round, shift by 16, clamp.
    always_comb begin
        rnd_g = i_full_range ? ycrgb_pkg::RND_HALF_DN : ycrgb_pkg::RND_HALF;
        sum_r = SW'(r1_y) + SW'(r1_rcr) + ycrgb_pkg::RND_HALF;
        sum_g = SW'(r1_y) - SW'(r1_gcb) - SW'(r1_gcr) + rnd_g;
        sum_b = SW'(r1_y) + SW'(r1_bcb) + ycrgb_pkg::RND_HALF;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld2) begin
            r2_red   <= clamp_u8(sum_r);
            r2_green <= clamp_u8(sum_g);
            r2_blue  <= clamp_u8(sum_b);
            r2_alpha <= r1_alpha;
        end
    end

    assign o_red   = r2_red;
    assign o_green = r2_green;
    assign o_blue  = r2_blue;
    assign o_alpha = r2_alpha;

endmodule

`default_nettype wire

// ----- hw/rtl/ycbcr_to_rgba_pixel_unit.sv -----
// YCbCr to RGBA8 pixel unit: top level with the premultiply stages and flow control.
//
// Slave stream carries one YCbCr pixel plus alpha per item; master stream returns one
// RGBA8 pixel per item, in order.
// Config port: i_cfg_we writes bit 0 of i_cfg_wdata into register i_cfg_idx
// (0 full_range, 1 alpha_present, 2 premultiply); write only with the pipe drained.
// Throughput: one item per cycle while m_axis_tready is high, set by the four register
// stages (products, sums and clamp, c*a+127, multiply by the reciprocal of 255);
// m_axis_tvalid is the valid bit of the fourth stage.
// Each stage loads when it is empty or the next stage moves, so bubbles close up.
// When the receiver stalls, the items pile up in the stages; s_axis_tready falls
// only when all four stages hold an item and m_axis_tready is low.
// Synchronous reset empties the pipe and clears the config registers to 0.
`default_nettype none
`include "ycbcr_to_rgba_pixel_unit_defines.svh"

module ycbcr_to_rgba_pixel_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic        i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // luma, blue_chroma, red_chroma, alpha_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata   // red, green, blue, alpha_out
);

    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [31:0] p;
        p = 32'(x) * 32'(ycrgb_pkg::RECIP_255);
        return p[ycrgb_pkg::RECIP_SHIFT+7:ycrgb_pkg::RECIP_SHIFT];
    endfunction

    logic                r_full_range;
    logic                r_alpha_present;
    logic                r_premultiply;

    logic [3:0]          r_vld;
    logic [3:0]          n_vld;
    logic [3:0]          ld;
    ycrgb_pkg::t_mtx_ctl mtx_ctl;

    logic [7:0]          m_red;
    logic [7:0]          m_green;
    logic [7:0]          m_blue;
    logic [7:0]          m_alpha;

    logic [15:0]         n3_xr;
    logic [15:0]         n3_xg;
    logic [15:0]         n3_xb;
    logic [15:0]         r3_xr;
    logic [15:0]         r3_xg;
    logic [15:0]         r3_xb;
    logic [7:0]          r3_red;
    logic [7:0]          r3_green;
    logic [7:0]          r3_blue;
    logic [7:0]          r3_alpha;
    logic                r3_pm;

    logic [7:0]          r4_red;
    logic [7:0]          r4_green;
    logic [7:0]          r4_blue;
    logic [7:0]          r4_alpha;

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_range    <= 1'b0;
            r_alpha_present <= 1'b0;
            r_premultiply   <= 1'b0;
        end else if (i_cfg_we) begin
            case (ycrgb_pkg::t_cfg_idx'(i_cfg_idx))
                ycrgb_pkg::CFG_FULL_RANGE:    r_full_range    <= i_cfg_wdata;
                ycrgb_pkg::CFG_ALPHA_PRESENT: r_alpha_present <= i_cfg_wdata;
                ycrgb_pkg::CFG_PREMULTIPLY:   r_premultiply   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Stage loads ripple back from the output.
    always_comb begin
        ld[3] = !r_vld[3] || m_axis_tready;
        for (int k = 2; k >= 0; k--) begin
            ld[k] = !r_vld[k] || ld[k+1];
        end
        n_vld = r_vld;
        if (ld[0]) begin
            n_vld[0] = s_axis_tvalid;
        end
        for (int k = 1; k < 4; k++) begin
            if (ld[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 4'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign mtx_ctl.ld1 = ld[0];
    assign mtx_ctl.ld2 = ld[1];

    ycrgb_matrix u_matrix (
        .i_clk           (i_clk),
        .i_ctl           (mtx_ctl),
        .i_full_range    (r_full_range),
        .i_alpha_present (r_alpha_present),
        .i_luma          (s_axis_tdata[7:0]),
        .i_blue_chroma   (s_axis_tdata[15:8]),
        .i_red_chroma    (s_axis_tdata[23:16]),
        .i_alpha_in      (s_axis_tdata[31:24]),
        .o_red           (m_red),
        .o_green         (m_green),
        .o_blue          (m_blue),
        .o_alpha         (m_alpha)
    );

    // Stage 3: c * a + 127
    always_comb begin
        n3_xr = 16'(m_red)   * 16'(m_alpha) + ycrgb_pkg::PREMUL_RND;
        n3_xg = 16'(m_green) * 16'(m_alpha) + ycrgb_pkg::PREMUL_RND;
        n3_xb = 16'(m_blue)  * 16'(m_alpha) + ycrgb_pkg::PREMUL_RND;
    end

    always_ff @(posedge i_clk) begin
        if (ld[2]) begin
            r3_xr    <= n3_xr;
            r3_xg    <= n3_xg;
            r3_xb    <= n3_xb;
            r3_red   <= m_red;
            r3_green <= m_green;
            r3_blue  <= m_blue;
            r3_alpha <= m_alpha;
            r3_pm    <= r_alpha_present && r_premultiply;
        end
    end

    // Stage 4: divide by 255 through the reciprocal, or pass the clamped value.
    always_ff @(posedge i_clk) begin
        if (ld[3]) begin
            r4_red   <= r3_pm ? div255(r3_xr) : r3_red;
            r4_green <= r3_pm ? div255(r3_xg) : r3_green;
            r4_blue  <= r3_pm ? div255(r3_xb) : r3_blue;
            r4_alpha <= r3_alpha;
        end
    end

    assign s_axis_tready = ld[0];
    assign m_axis_tvalid = r_vld[3];
    assign m_axis_tdata  = {r4_alpha, r4_blue, r4_green, r4_red};

    `YCRGB_ASSERT_NOW(a_opaque_without_alpha, m_axis_tvalid && !r_alpha_present,
        r4_alpha == ycrgb_pkg::ALPHA_OPAQUE, "alpha not opaque with alpha plane absent")
    `YCRGB_ASSERT_NOW(a_premul_bounded,
        m_axis_tvalid && r_alpha_present && r_premultiply,
        (r4_red <= r4_alpha) && (r4_green <= r4_alpha) && (r4_blue <= r4_alpha),
        "premultiplied channel exceeds alpha")
    `YCRGB_ASSERT_NEXT(a_stage_advance, r_vld[1] && ld[2], r_vld[2],
        "item lost between stages 2 and 3")
    `YCRGB_ASSERT_NOW(a_stall_only_when_full, !s_axis_tready,
        (r_vld == 4'b1111) && !m_axis_tready, "input stalled with room in the pipe")

endmodule

`default_nettype wire

// ----- sim/tb_ycbcr_to_rgba_pixel_unit.sv -----
// Testbench for the YCbCr to RGBA8 pixel unit: directed and random pixels, all modes.
`timescale 1ns / 100ps

module tb_ycbcr_to_rgba_pixel_unit;

    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_GAP = 12;
    localparam int TAIL_CYCLES = 8;
    localparam int RANDOM_PER_MODE = 72;
    localparam logic [1:0] CFG_UNUSED_IDX = 2'd3;

    // BT.601 coefficients, 16 fractional bits
    localparam int Q16_HALF = 32768;
    localparam int LIM_Y = 76309;
    localparam int LIM_RCR = 104597;
    localparam int LIM_GCB = 25675;
    localparam int LIM_GCR = 53279;
    localparam int LIM_BCB = 132201;
    localparam int FULL_RCR = 91881;
    localparam int FULL_GCB = 22554;
    localparam int FULL_GCR = 46802;
    localparam int FULL_BCB = 116130;
    localparam int CHROMA_ZERO = 128;
    localparam int LUMA_FLOOR = 16;
    localparam int OPAQUE = 255;

    // red in the low byte, alpha in the high byte
    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_rgba;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic        i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;

    // mirror of the mode registers
    logic full_range_q;
    logic alpha_present_q;
    logic premultiply_q;

    logic send_idle;
    logic recv_idle;
    int   mismatch_count;
    int   cycle_count;
    t_rgba expected_pixels[$];

    ycbcr_to_rgba_pixel_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_ycbcr_to_rgba_pixel_unit NOT OK");
            $finish;
        end
    end

    function automatic int round_q16(input int v);
        return (v + Q16_HALF) >>> 16;
    endfunction

    function automatic logic [7:0] clamp_u8(input int v);
        if (v < 0) return 8'd0;
        if (v > 255) return 8'd255;
        return v[7:0];
    endfunction

    function automatic logic [7:0] premultiply_ch(input logic [7:0] c, input logic [7:0] a);
        int prod;
        prod = (int'(c) * int'(a) + 127) / 255;
        return prod[7:0];
    endfunction

    function automatic t_rgba predict_rgba(input logic [31:0] pix);
        int y, cb, cr, ys, r, g, b;
        t_rgba px;
        y = int'(pix[7:0]);
        cb = int'(pix[15:8]) - CHROMA_ZERO;
        cr = int'(pix[23:16]) - CHROMA_ZERO;
        if (full_range_q) begin
            r = y + round_q16(FULL_RCR * cr);
            g = y - round_q16(FULL_GCB * cb + FULL_GCR * cr);
            b = y + round_q16(FULL_BCB * cb);
        end else begin
            ys = (y > LUMA_FLOOR ? y - LUMA_FLOOR : 0) * LIM_Y;
            r = round_q16(ys + LIM_RCR * cr);
            g = round_q16(ys - LIM_GCB * cb - LIM_GCR * cr);
            b = round_q16(ys + LIM_BCB * cb);
        end
        px.red = clamp_u8(r);
        px.green = clamp_u8(g);
        px.blue = clamp_u8(b);
        px.alpha = OPAQUE[7:0];
        if (alpha_present_q) begin
            px.alpha = pix[31:24];
            if (premultiply_q) begin
                px.red = premultiply_ch(px.red, px.alpha);
                px.green = premultiply_ch(px.green, px.alpha);
                px.blue = premultiply_ch(px.blue, px.alpha);
            end
        end
        return px;
    endfunction

    function automatic logic [31:0] pack_pixel(input logic [7:0] y, input logic [7:0] cb,
                                               input logic [7:0] cr, input logic [7:0] a);
        return {a, cr, cb, y};
    endfunction

    function automatic logic [7:0] edge_byte();
        case ($urandom_range(0, 3))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd254;
            default: return 8'd255;
        endcase
    endfunction

    // half uniform; the rest pile onto dark luma, saturated chroma or edge alpha
    function automatic logic [31:0] random_pixel();
        logic [31:0] pix;
        pix = $urandom;
        case ($urandom_range(0, 5))
            0: pix[7:0] = 8'($urandom_range(0, 20));
            1: begin
                pix[15:8] = edge_byte();
                pix[23:16] = edge_byte();
            end
            2: pix[31:24] = edge_byte();
            default: ;
        endcase
        return pix;
    endfunction

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_rgba want, got;
        if (i_rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
            got = m_axis_tdata;
            if (expected_pixels.size() == 0) begin
                $error("unexpected item: %h", m_axis_tdata);
                mismatch_count++;
            end else begin
                want = expected_pixels.pop_front();
                check_field("red", want.red, got.red);
                check_field("green", want.green, got.green);
                check_field("blue", want.blue, got.blue);
                check_field("alpha_out", want.alpha, got.alpha);
            end
        end
    end

    // receiver with random stalls
    initial begin
        int gap;
        m_axis_tready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            gap = recv_idle ? $urandom_range(0, MAX_GAP) : 0;
            repeat (gap) begin
                m_axis_tready <= 1'b0;
                @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1));
        end
    end

    task automatic send_pixel(input logic [31:0] pix);
        int gap;
        gap = send_idle ? $urandom_range(0, MAX_GAP) : 0;
        repeat (gap) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pix;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        expected_pixels.push_back(predict_rgba(pix));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
    endtask

    // leaves the write enable high; set_mode lowers it after the last write
    task automatic write_reg(input logic [1:0] idx, input logic val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            ycrgb_pkg::CFG_FULL_RANGE: full_range_q = val;
            ycrgb_pkg::CFG_ALPHA_PRESENT: alpha_present_q = val;
            ycrgb_pkg::CFG_PREMULTIPLY: premultiply_q = val;
            default: ;
        endcase
    endtask

    task automatic set_mode(input logic full, input logic alpha, input logic premul);
        wait_drained();
        write_reg(ycrgb_pkg::CFG_FULL_RANGE, full);
        write_reg(ycrgb_pkg::CFG_ALPHA_PRESENT, alpha);
        write_reg(ycrgb_pkg::CFG_PREMULTIPLY, premul);
        i_cfg_we <= 1'b0;
    endtask

    // reset mode: limited range, no alpha; luma around the black level
    task automatic test_reset_defaults();
        send_pixel(pack_pixel(8'd0, 8'd128, 8'd128, 8'd0));
        send_pixel(pack_pixel(8'd15, 8'd128, 8'd128, 8'd255));
        send_pixel(pack_pixel(8'd16, 8'd128, 8'd128, 8'd7));
        send_pixel(pack_pixel(8'd17, 8'd0, 8'd255, 8'd0));
        send_pixel(pack_pixel(8'd255, 8'd255, 8'd255, 8'd255));
    endtask

    // saturating chroma drives the channels past both ends
    task automatic test_chroma_clamp();
        set_mode(1'b1, 1'b0, 1'b0);
        send_pixel(pack_pixel(8'd255, 8'd0, 8'd255, 8'd0));
        send_pixel(pack_pixel(8'd0, 8'd255, 8'd0, 8'd0));
        send_pixel(pack_pixel(8'd128, 8'd0, 8'd0, 8'd0));
        send_pixel(pack_pixel(8'd128, 8'd255, 8'd255, 8'd0));
        send_pixel(pack_pixel(8'd0, 8'd0, 8'd0, 8'd255));
    endtask

    // premultiply is ignored while alpha is absent
    task automatic test_alpha_absent();
        set_mode(1'b0, 1'b0, 1'b1);
        send_pixel(pack_pixel(8'd200, 8'd100, 8'd150, 8'd0));
        send_pixel(pack_pixel(8'd235, 8'd128, 8'd128, 8'h5a));
    endtask

    task automatic test_premultiply();
        set_mode(1'b1, 1'b1, 1'b1);
        send_pixel(pack_pixel(8'd255, 8'd128, 8'd128, 8'd0));
        send_pixel(pack_pixel(8'd255, 8'd128, 8'd128, 8'd255));
        send_pixel(pack_pixel(8'd255, 8'd128, 8'd128, 8'd128));
        send_pixel(pack_pixel(8'd200, 8'd90, 8'd200, 8'd1));
    endtask

    // writes to the spare index must not disturb the mode
    task automatic test_unused_index();
        wait_drained();
        write_reg(ycrgb_pkg::CFG_FULL_RANGE, 1'b0);
        write_reg(CFG_UNUSED_IDX, 1'b1);
        write_reg(CFG_UNUSED_IDX, 1'b0);
        write_reg(CFG_UNUSED_IDX, 1'b1);
        i_cfg_we <= 1'b0;
        send_pixel(pack_pixel(8'd10, 8'd128, 8'd128, 8'd99));
        send_pixel(pack_pixel(8'd120, 8'd60, 8'd190, 8'd200));
        send_pixel(pack_pixel(8'd255, 8'd255, 8'd0, 8'd128));
    endtask

    task automatic test_random_modes();
        logic [2:0] mode;
        for (int m = 0; m < 8; m++) begin
            mode = 3'(m);
            set_mode(mode[0], mode[1], mode[2]);
            // modes 3 and 6 send with no idling, modes 5 and 6 receive with no idling
            send_idle = !(m == 3 || m == 6);
            recv_idle = !(m == 5 || m == 6);
            for (int n = 0; n < RANDOM_PER_MODE; n++) send_pixel(random_pixel());
        end
        send_idle = 1'b1;
        recv_idle = 1'b1;
    endtask

    // sender holds off until the pipe is empty, then resumes
    task automatic test_drain_pause();
        set_mode(1'b1, 1'b1, 1'b1);
        for (int n = 0; n < 40; n++) begin
            if (n % 10 == 9) wait_drained();
            send_pixel(random_pixel());
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= ycrgb_pkg::CFG_FULL_RANGE;
        i_cfg_wdata <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        full_range_q = 1'b0;
        alpha_present_q = 1'b0;
        premultiply_q = 1'b0;
        send_idle = 1'b1;
        recv_idle = 1'b1;
        mismatch_count = 0;
        cycle_count = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_chroma_clamp();
        test_alpha_absent();
        test_premultiply();
        test_unused_index();
        test_random_modes();
        test_drain_pause();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb_ycbcr_to_rgba_pixel_unit OK");
        end else begin
            $display("tb_ycbcr_to_rgba_pixel_unit NOT OK");
        end
        $finish;
    end

endmodule
